// ===== src/gyro_yaw_calibrate_filter_integrate_macros.svh =====
// Assertion macros shared by the yaw gyro block checkers.
`ifndef GYRO_YAW_CALIBRATE_FILTER_INTEGRATE_MACROS_SVH
`define GYRO_YAW_CALIBRATE_FILTER_INTEGRATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GYAW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GYAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gyaw_pkg.sv =====
// Shared types and constants of the yaw gyro calibration, filter and integrator block.
package gyaw_pkg;

  // Field and state widths.
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned MAX_CALIB  = 16384;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned SUM_W      = 31;
  localparam int unsigned OFS_W      = 25;
  localparam int unsigned RATE_W     = 26;
  localparam int unsigned ANG_W      = 64;
  localparam int unsigned OUT_RATE_W = 25;
  localparam int unsigned OUT_ANG_W  = 48;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned Q8_W       = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned ALPHA_W    = 17;

  // Shared multiplier and divider.
  localparam int unsigned MUL_A_W   = RATE_W;
  localparam int unsigned MUL_B_W   = ALPHA_W + 1;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_W     = SUM_W + Q8_W;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(65536);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB_COUNT  = 3'd0,
    CFG_SCALE_POS    = 3'd1,
    CFG_SCALE_NEG    = 3'd2,
    CFG_FILTER_ALPHA = 3'd3,
    CFG_STEP_SECONDS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]   calib_count;
    logic [SCALE_W-1:0] scale_pos;
    logic [SCALE_W-1:0] scale_neg;
    logic [ALPHA_W-1:0] filter_alpha;
    logic [SCALE_W-1:0] step_seconds;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_angle;
    logic sum;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic dev;
    logic mul_sc;
    logic cur;
    logic mul_a;
    logic mul_b;
    logic filt;
    logic mul_t;
    logic acc;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_clear;
    logic calibrated;
    logic count_below;
    logic div_last;
  } sts_t;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_DECIDE  = 12'b0000_0000_0010,
    ST_DIV     = 12'b0000_0000_0100,
    ST_DIV_FIN = 12'b0000_0000_1000,
    ST_MUL_SC  = 12'b0000_0001_0000,
    ST_CUR     = 12'b0000_0010_0000,
    ST_MUL_A   = 12'b0000_0100_0000,
    ST_MUL_B   = 12'b0000_1000_0000,
    ST_FILT    = 12'b0001_0000_0000,
    ST_MUL_T   = 12'b0010_0000_0000,
    ST_ACC     = 12'b0100_0000_0000,
    ST_OUT     = 12'b1000_0000_0000
  } state_e;

endpackage

// ===== src/gyro_yaw_calibrate_filter_integrate.sv =====
// Top level of the yaw gyro calibration, low-pass filter and angle integrator.
// The block takes one transfer at a time and returns exactly one result per transfer.
// A calibration sample or an angle reset request goes from acceptance through the decide
// state to the output state, where its result is loaded into the result register. A sample
// after calibration also passes four times through the one shared 26 x 18 multiplier,
// with a register after each. The sample that completes calibration instead passes through
// the bit-serial restoring divider that produces one of 39 quotient bits per cycle. A
// result still stalled in the output register delays the load of the next one until its
// transfer completes. A new request is taken once the previous result has been loaded
// into the output register; that result may still wait there.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i. The user must write
// it only while idle; the block itself does not enforce this.
module gyro_yaw_calibrate_filter_integrate (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      req_type_i,
  input  logic signed [gyaw_pkg::RAW_W-1:0]         raw_rate_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      ready_res_o,
  output logic signed [gyaw_pkg::OUT_RATE_W-1:0]    rate_q8_o,
  output logic signed [gyaw_pkg::OUT_ANG_W-1:0]     angle_q8_o,
  input  logic                                      cfg_we_i,
  input  logic [gyaw_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [gyaw_pkg::CFG_DATA_W-1:0]           cfg_data_i
);
  import gyaw_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers.
  gyaw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencing controller.
  gyaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic datapath.
  gyaw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .req_type_i  (req_type_i),
    .raw_rate_i  (raw_rate_i),
    .sts_o       (sts),
    .ready_res_o (ready_res_o),
    .rate_q8_o   (rate_q8_o),
    .angle_q8_o  (angle_q8_o)
  );

endmodule

// ===== src/gyaw_cfg.sv =====
// Configuration registers of the yaw gyro block.
module gyaw_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gyaw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gyaw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output gyaw_pkg::cfg_t                   cfg_o
);
  import gyaw_pkg::*;

  cfg_t cfg_q;

  // Register writes by index; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_count  <= CNT_W'(512);
      cfg_q.scale_pos    <= SCALE_W'(3996);
      cfg_q.scale_neg    <= SCALE_W'(3996);
      cfg_q.filter_alpha <= ALPHA_W'(19661);
      cfg_q.step_seconds <= SCALE_W'(393);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CALIB_COUNT:  cfg_q.calib_count  <= cfg_data_i[CNT_W-1:0];
        CFG_SCALE_POS:    cfg_q.scale_pos    <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_NEG:    cfg_q.scale_neg    <= cfg_data_i[SCALE_W-1:0];
        CFG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data_i[ALPHA_W-1:0];
        CFG_STEP_SECONDS: cfg_q.step_seconds <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/gyaw_ctrl.sv =====
// Controller state machine that sequences the yaw gyro datapath.
module gyaw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  gyaw_pkg::sts_t sts_i,
  output gyaw_pkg::cmd_t cmd_o
);
  import gyaw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can be loaded when empty or when its transfer completes.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.req_clear) begin
          cmd_o.clr_angle = 1'b1;
          state_d         = ST_OUT;
        end else if (!sts_i.calibrated) begin
          if (sts_i.count_below) begin
            cmd_o.sum = 1'b1;
            state_d   = ST_OUT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end else begin
          cmd_o.dev = 1'b1;
          state_d   = ST_MUL_SC;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = ST_OUT;
      end
      ST_MUL_SC: begin
        cmd_o.mul_sc = 1'b1;
        state_d      = ST_CUR;
      end
      ST_CUR: begin
        cmd_o.cur = 1'b1;
        state_d   = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = ST_MUL_T;
      end
      ST_MUL_T: begin
        cmd_o.mul_t = 1'b1;
        state_d     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/gyaw_dp.sv =====
// Datapath: calibration sum, offset divider, shared multiplier, filter and integrator.
module gyaw_dp (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  gyaw_pkg::cmd_t                            cmd_i,
  input  gyaw_pkg::cfg_t                            cfg_i,
  input  logic                                      req_type_i,
  input  logic signed [gyaw_pkg::RAW_W-1:0]         raw_rate_i,
  output gyaw_pkg::sts_t                            sts_o,
  output logic                                      ready_res_o,
  output logic signed [gyaw_pkg::OUT_RATE_W-1:0]    rate_q8_o,
  output logic signed [gyaw_pkg::OUT_ANG_W-1:0]     angle_q8_o
);
  import gyaw_pkg::*;

  // Captured request.
  logic                    req_q;
  logic [RAW_W-1:0]        raw_q;

  // Block state.
  logic [CNT_W-1:0]        sample_count_q;
  logic [SUM_W-1:0]        raw_sum_q;
  logic [OFS_W-1:0]        zero_offset_q;
  logic [RATE_W-1:0]       last_rate_q;
  logic [ANG_W-1:0]        angle_q;
  logic                    calibrated_q;

  // Intermediate values of the sample sequence.
  logic [RATE_W-1:0]       dev_q;
  logic [RATE_W-1:0]       cur_q;
  logic [PROD_W-1:0]       prod_q;
  logic [PROD_W-1:0]       acc_q;

  // Divider registers.
  logic [DIV_W-1:0]        div_quo_q;
  logic [CNT_W-1:0]        div_rem_q;
  logic                    div_neg_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;

  // Result registers.
  logic                    ready_out_q;
  logic [OUT_RATE_W-1:0]   rate_out_q;
  logic [OUT_ANG_W-1:0]    angle_out_q;

  logic [CNT_W-1:0]        eff_count;
  logic [RATE_W-1:0]       dev_d;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W:0]          div_trial;
  logic                    div_ge;
  logic [OFS_W-1:0]        div_q;
  logic [ALPHA_W-1:0]      alpha_eff;
  logic [SCALE_W-1:0]      scale_sel;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]       cur_rnd;
  logic [PROD_W-1:0]       filt_sum;
  logic [ANG_W:0]          ang_sum;
  logic [ANG_W-1:0]        ang_next;

  // Calibration length clamped to one through the maximum.
  always_comb begin
    if (cfg_i.calib_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (cfg_i.calib_count > CNT_W'(MAX_CALIB)) begin
      eff_count = CNT_W'(MAX_CALIB);
    end else begin
      eff_count = cfg_i.calib_count;
    end
  end

  // Deviation in Q.8: raw sample shifted up by eight, minus the offset.
  assign dev_d = {{(RATE_W - RAW_W - Q8_W){raw_q[RAW_W-1]}}, raw_q, {Q8_W{1'b0}}}
               - {{(RATE_W - OFS_W){zero_offset_q[OFS_W-1]}}, zero_offset_q};

  // Magnitude of the calibration sum for the sign-magnitude division.
  assign sum_mag = raw_sum_q[SUM_W-1] ? (~raw_sum_q + SUM_W'(1)) : raw_sum_q;

  // One restoring division step per cycle.
  assign div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, sample_count_q});
  assign div_q     = div_quo_q[OFS_W-1:0];

  // Filter weight clamped to one.
  assign alpha_eff = (cfg_i.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.filter_alpha;
  assign scale_sel = dev_q[RATE_W-1] ? cfg_i.scale_neg : cfg_i.scale_pos;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = dev_q;
    mul_b = {{(MUL_B_W - SCALE_W){1'b0}}, scale_sel};
    if (cmd_i.mul_a) begin
      mul_a = cur_q;
      mul_b = {1'b0, alpha_eff};
    end else if (cmd_i.mul_b) begin
      mul_a = last_rate_q;
      mul_b = {1'b0, ALPHA_ONE - alpha_eff};
    end else if (cmd_i.mul_t) begin
      mul_a = last_rate_q;
      mul_b = {{(MUL_B_W - SCALE_W){1'b0}}, cfg_i.step_seconds};
    end
  end

  assign mul_p = $signed(mul_a) * $signed(mul_b);

  // Round half up and drop the Q0.16 fraction.
  assign cur_rnd  = prod_q + ROUND_HALF;
  assign filt_sum = acc_q + prod_q + ROUND_HALF;

  // Saturating angle accumulation.
  assign ang_sum = {angle_q[ANG_W-1], angle_q}
                 + {{(ANG_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  always_comb begin
    if (ang_sum[ANG_W] != ang_sum[ANG_W-1]) begin
      ang_next = ang_sum[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      ang_next = ang_sum[ANG_W-1:0];
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      raw_q <= raw_rate_i;
    end
    if (cmd_i.dev) begin
      dev_q <= dev_d;
    end
    if (cmd_i.mul_sc || cmd_i.mul_a || cmd_i.mul_b || cmd_i.mul_t) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_b) begin
      acc_q <= prod_q;
    end
    if (cmd_i.cur) begin
      cur_q <= cur_rnd[FRAC_W+RATE_W-1:FRAC_W];
    end
    if (cmd_i.div_start) begin
      div_quo_q <= {sum_mag, {Q8_W{1'b0}}} + DIV_W'(sample_count_q >> 1);
      div_rem_q <= '0;
      div_neg_q <= raw_sum_q[SUM_W-1];
    end else if (cmd_i.div_step) begin
      div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
      div_rem_q <= div_ge ? CNT_W'(div_trial - {1'b0, sample_count_q})
                          : div_trial[CNT_W-1:0];
    end
    if (cmd_i.load_out) begin
      ready_out_q <= calibrated_q;
      rate_out_q  <= last_rate_q[OUT_RATE_W-1:0];
      angle_out_q <= angle_q[ANG_W-1:ANG_W-OUT_ANG_W];
    end
  end

  // Block state and divider step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
      raw_sum_q      <= '0;
      zero_offset_q  <= '0;
      last_rate_q    <= '0;
      angle_q        <= '0;
      calibrated_q   <= 1'b0;
      div_cnt_q      <= '0;
    end else begin
      if (cmd_i.sum) begin
        raw_sum_q      <= raw_sum_q + {{(SUM_W - RAW_W){raw_q[RAW_W-1]}}, raw_q};
        sample_count_q <= sample_count_q + CNT_W'(1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
      if (cmd_i.div_fin) begin
        zero_offset_q <= div_neg_q ? (~div_q + OFS_W'(1)) : div_q;
        calibrated_q  <= 1'b1;
        last_rate_q   <= '0;
      end
      if (cmd_i.filt) begin
        last_rate_q <= filt_sum[FRAC_W+RATE_W-1:FRAC_W];
      end
      if (cmd_i.clr_angle || cmd_i.div_fin) begin
        angle_q <= '0;
      end else if (cmd_i.acc) begin
        angle_q <= ang_next;
      end
    end
  end

  assign sts_o.req_clear   = req_q;
  assign sts_o.calibrated  = calibrated_q;
  assign sts_o.count_below = (sample_count_q < eff_count);
  assign sts_o.div_last    = (div_cnt_q == DIV_CNT_W'(1));

  assign ready_res_o = ready_out_q;
  assign rate_q8_o   = rate_out_q;
  assign angle_q8_o  = angle_out_q;

endmodule

// ===== src/gyaw_chk.sv =====
// Port-level checker for the yaw gyro block, with its bind statement.
`include "gyro_yaw_calibrate_filter_integrate_macros.svh"

module gyaw_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   ready_res_o,
  input logic signed [gyaw_pkg::OUT_RATE_W-1:0] rate_q8_o,
  input logic signed [gyaw_pkg::OUT_ANG_W-1:0]  angle_q8_o
);
  import gyaw_pkg::*;

  logic                          seen_ready_q;
  logic                          out_wait;
  logic [OUT_RATE_W+OUT_ANG_W:0] out_data;

  // A result waiting under stall, and the fields it carries.
  assign out_wait = out_valid_o && out_stall_i;
  assign out_data = {ready_res_o, rate_q8_o, angle_q8_o};

  // Remember that a delivered result has reported completed calibration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ready_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && ready_res_o) begin
      seen_ready_q <= 1'b1;
    end
  end

  // A stalled result stays valid and unchanged.
  `GYAW_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data), "stalled result changed")

  // The block is busy in the cycle after it takes a transfer.
  `GYAW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // The filtered rate reads zero until calibration completes.
  `GYAW_ASSERT_SAME(a_rate_zero_uncal, out_valid_o && !ready_res_o, rate_q8_o == '0, "rate before ready")

  // Once calibrated, the block stays calibrated.
  `GYAW_ASSERT_SAME(a_ready_sticky, out_valid_o && seen_ready_q, ready_res_o, "ready flag dropped")

endmodule

bind gyro_yaw_calibrate_filter_integrate gyaw_chk u_gyaw_chk (.*);
